/* src/dcg_pkg.sv */
// ----------------------------------------------------------------------------
// dcg_pkg
// Shared types and constants of the digit combination generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dcg_pkg;

  localparam int unsigned MAX_DIGITS    = 9;
  localparam int unsigned DEFAULT_RADIX = 10;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned COUNT_W       = 4;

  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 4'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_STEP,
    OP_FILL,
    OP_ROT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT,
    ST_COMMA,
    ST_SPACE
  } state_e;

  typedef struct packed {
    cell_op_e            op;
    logic [COUNT_W-1:0]  k;
    logic                any_found;
  } cell_ctrl_t;

endpackage : dcg_pkg

`default_nettype wire

/* src/digit_combination_generator_core.sv */
// ----------------------------------------------------------------------------
// digit_combination_generator_core
// Lexicographic k-combination generator over the digits below RADIX (decimal
// by default), one character per cycle while emitting and the output is ready.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in idle, the cell row is refilled after a
// step (not after a load), then k digit characters and two separators are
// emitted; the final set omits the separators. A new request is taken only in
// idle, once the previous combination is out; output stalls hold each character.
// Reset: state returns to the first combination, digit_count to 2; the digit
// cells are not cleared and are loaded on the first request.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_combination_generator_core #(
  parameter int unsigned RADIX = dcg_pkg::DEFAULT_RADIX
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [dcg_pkg::COUNT_W-1:0]  cfg_data_i,     // digit_count
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire [7:0]                   s_axis_tdata,   // [0] restart, [7:1] zero
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] out_char
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser    // [0] final_combination
);
  import dcg_pkg::*;

  localparam logic [COUNT_W-1:0] RADIX_K = COUNT_W'(RADIX);
  localparam logic [COUNT_W-1:0] MAX_K   = COUNT_W'(MAX_DIGITS);

  logic [DIGIT_W-1:0] digit_w [MAX_DIGITS];
  logic               dirty_w [MAX_DIGITS];
  logic               found_w [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] dirty_vec;

  cell_ctrl_t ctrl;

  state_e state_q, state_d;
  logic [COUNT_W-1:0] k_q;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               at_beg_q, at_beg_d;
  logic               fin_walk_q, fin_walk_d;
  logic               fin_q, fin_d;
  logic               m_valid_q;
  logic [7:0]         m_char_q, m_char_d;
  logic               m_last_q, m_last_d;
  logic               m_fin_q, m_fin_d;

  logic               accept;
  logic               restart;
  logic               k_ok;
  logic               ab;
  logic               fn;
  logic               any_found;
  logic               dirty_any;
  logic               can_push;
  logic               push;
  logic               fin_cur;
  logic               last_digit;
  logic [COUNT_W-1:0] k_m1;

  genvar g;
  generate
    for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
      logic [DIGIT_W-1:0] left_digit;
      logic               left_dirty;
      logic [DIGIT_W-1:0] right_digit;
      logic               right_found;
      if (g == 0) begin : g_head
        assign left_digit = '0;
        assign left_dirty = 1'b0;
      end else begin : g_body
        assign left_digit = digit_w[g-1];
        assign left_dirty = dirty_w[g-1];
      end
      if (g == MAX_DIGITS - 1) begin : g_tail
        assign right_digit = digit_w[0];
        assign right_found = 1'b0;
      end else begin : g_mid
        assign right_digit = digit_w[g+1];
        assign right_found = found_w[g+1];
      end
      dcg_cell #(
        .INDEX (g),
        .RADIX (RADIX)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl),
        .left_digit_i  (left_digit),
        .left_dirty_i  (left_dirty),
        .right_digit_i (right_digit),
        .wrap_digit_i  (digit_w[0]),
        .right_found_i (right_found),
        .digit_o       (digit_w[g]),
        .dirty_o       (dirty_w[g]),
        .found_o       (found_w[g])
      );
      assign dirty_vec[g] = dirty_w[g];
    end
  endgenerate

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0];
  assign k_ok          = (k_q != '0) && (k_q <= MAX_K) && (k_q <= RADIX_K);
  assign ab            = at_beg_q | restart;
  assign fn            = fin_walk_q & ~restart;
  assign any_found     = found_w[0];
  assign dirty_any     = |dirty_vec;
  assign can_push      = !m_valid_q || m_axis_tready;
  assign k_m1          = k_q - 1'b1;
  assign last_digit    = (cnt_q == k_m1);
  assign fin_cur       = (cnt_q == '0) ? (digit_w[0] == RADIX_K - k_q) : fin_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && k_ok) begin
          if (ab) begin
            state_d = ST_EMIT;
          end else if (!fn && any_found) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (!dirty_any) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_push && last_digit) begin
          state_d = fin_cur ? ST_IDLE : ST_COMMA;
        end
      end
      ST_COMMA: begin
        if (can_push) begin
          state_d = ST_SPACE;
        end
      end
      ST_SPACE: begin
        if (can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.k         = k_q;
    ctrl.any_found = any_found;
    push           = 1'b0;
    m_char_d       = m_char_q;
    m_last_d       = m_last_q;
    m_fin_d        = m_fin_q;
    cnt_d          = cnt_q;
    fin_d          = fin_q;
    at_beg_d       = at_beg_q;
    fin_walk_d     = fin_walk_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          at_beg_d   = ab;
          fin_walk_d = fn;
          if (k_ok) begin
            if (ab) begin
              ctrl.op  = OP_LOAD;
              at_beg_d = 1'b0;
            end else if (!fn) begin
              if (any_found) begin
                ctrl.op = OP_STEP;
              end else begin
                fin_walk_d = 1'b1;
              end
            end
          end
        end
      end
      ST_FILL: begin
        ctrl.op = OP_FILL;
      end
      ST_EMIT: begin
        if (can_push) begin
          ctrl.op  = OP_ROT;
          push     = 1'b1;
          m_char_d = CHAR_ZERO + {4'b0000, digit_w[0]};
          m_last_d = fin_cur && last_digit;
          m_fin_d  = fin_cur;
          fin_d    = fin_cur;
          cnt_d    = cnt_q + 1'b1;
          if (last_digit && fin_cur) begin
            fin_walk_d = 1'b1;
          end
        end
      end
      ST_COMMA: begin
        if (can_push) begin
          push     = 1'b1;
          m_char_d = CHAR_COMMA;
          m_last_d = 1'b0;
          m_fin_d  = 1'b0;
        end
      end
      ST_SPACE: begin
        if (can_push) begin
          push     = 1'b1;
          m_char_d = CHAR_SPACE;
          m_last_d = 1'b1;
          m_fin_d  = 1'b0;
        end
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= DIGIT_COUNT_RESET;
      cnt_q      <= '0;
      at_beg_q   <= 1'b1;
      fin_walk_q <= 1'b0;
      fin_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      at_beg_q   <= at_beg_d;
      fin_walk_q <= fin_walk_d;
      fin_q      <= fin_d;
      if (cfg_valid_i && cfg_ready_o) begin
        k_q <= cfg_data_i;
      end
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_char_q <= m_char_d;
    m_last_q <= m_last_d;
    m_fin_q  <= m_fin_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_char_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_fin_q;

endmodule : digit_combination_generator_core

`default_nettype wire

/* src/dcg_cell.sv */
// ----------------------------------------------------------------------------
// dcg_cell
// One digit position: holds its digit, finds the step position with its
// neighbors, refills from its left neighbor and rotates toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dcg_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned RADIX = dcg_pkg::DEFAULT_RADIX
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire dcg_pkg::cell_ctrl_t    ctrl_i,
  input  wire [dcg_pkg::DIGIT_W-1:0]  left_digit_i,
  input  wire                         left_dirty_i,
  input  wire [dcg_pkg::DIGIT_W-1:0]  right_digit_i,
  input  wire [dcg_pkg::DIGIT_W-1:0]  wrap_digit_i,
  input  wire                         right_found_i,
  output logic [dcg_pkg::DIGIT_W-1:0] digit_o,
  output logic                        dirty_o,
  output logic                        found_o
);
  import dcg_pkg::*;

  localparam logic [5:0]         BASE  = 6'(RADIX + INDEX);
  localparam logic [COUNT_W-1:0] IDX   = COUNT_W'(INDEX);
  localparam logic [DIGIT_W-1:0] FIRST = DIGIT_W'(INDEX);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               dirty_q, dirty_d;
  logic               active;
  logic               qualify;
  logic [5:0]         bound;

  assign active  = IDX < ctrl_i.k;
  assign bound   = BASE - {2'b00, ctrl_i.k};
  assign qualify = active && ({2'b00, digit_q} < bound);
  assign found_o = qualify | right_found_i;
  assign digit_o = digit_q;
  assign dirty_o = dirty_q;

  always_comb begin
    digit_d = digit_q;
    dirty_d = dirty_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        digit_d = FIRST;
        dirty_d = 1'b0;
      end
      OP_STEP: begin
        if (qualify && !right_found_i) begin
          digit_d = digit_q + 1'b1;
        end
        dirty_d = active && !found_o && ctrl_i.any_found;
      end
      OP_FILL: begin
        if (dirty_q && !left_dirty_i) begin
          digit_d = left_digit_i + 1'b1;
          dirty_d = 1'b0;
        end
      end
      OP_ROT: begin
        if (active) begin
          digit_d = (IDX == ctrl_i.k - 1'b1) ? wrap_digit_i : right_digit_i;
        end
      end
      default: begin
        digit_d = digit_q;
        dirty_d = dirty_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b0;
    end else begin
      dirty_q <= dirty_d;
    end
  end

endmodule : dcg_cell

`default_nettype wire
